// ----- src/smr_pkg.sv -----
// Shared types and constants for the sound event register mapper.
// Used by smr_map and sound_event_register_mapper_core; no dependencies.
`default_nettype none
package smr_pkg;

    localparam int TRACK_COUNT_DEF = 17;

    typedef enum logic [2:0] {
        CMD_VOLUME   = 3'd0,
        CMD_RATE_VOL = 3'd1,
        CMD_REG_WR   = 3'd2,
        CMD_PERIOD   = 3'd3,
        CMD_NOISE    = 3'd4,
        CMD_MIXER    = 3'd5,
        CMD_PATCH    = 3'd6,
        CMD_UNSUP    = 3'd7
    } cmd_t;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_TRACK   = 3'd1;
    localparam logic [2:0] ST_BAD_REG     = 3'd2;
    localparam logic [2:0] ST_NO_PATCH    = 3'd3;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

    localparam logic [2:0] WR_VOLUME = 3'd0;
    localparam logic [2:0] WR_ENV    = 3'd1;
    localparam logic [2:0] WR_FREQ   = 3'd2;
    localparam logic [2:0] WR_PATCH  = 3'd3;
    localparam logic [2:0] WR_RHYTHM = 3'd4;

    localparam logic [1:0] CHIP_TONE = 2'd0;
    localparam logic [1:0] CHIP_WAVE = 2'd1;
    localparam logic [1:0] CHIP_FM   = 2'd2;

    localparam logic [7:0]  MIXER_RESET  = 8'hB8;
    localparam logic [7:0]  FM_VOL_RESET = 8'h0F;
    localparam logic [7:0]  FM_SNAP_LO   = 8'hAC;
    localparam logic [7:0]  FM_SNAP_HI   = 8'h59;
    localparam logic [15:0] FM_STEP_UP   = 16'h0153;
    localparam logic [15:0] FM_STEP_DN   = 16'hFEAD;
    localparam logic [7:0]  FM_RHYTHM    = 8'h0E;
    localparam logic [7:0]  FM_LO_BASE   = 8'h10;
    localparam logic [7:0]  FM_HI_BASE   = 8'h20;
    localparam logic [7:0]  FM_VOL_BASE  = 8'h30;
    localparam logic [7:0]  FM_LAST_REG  = 8'h38;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [4:0]         track;
        logic signed [15:0] arg_a;
        logic signed [15:0] arg_b;
        logic [31:0]        tick_time;
        logic               tick_start;
    } in_t;

    typedef struct packed {
        logic        write_valid;
        logic [1:0]  chip;
        logic [1:0]  bus_port;
        logic [7:0]  reg_address;
        logic [7:0]  reg_value;
        logic [2:0]  write_reason;
        logic [15:0] sequence_number;
        logic [31:0] stamp;
        logic [4:0]  source_track;
        logic [2:0]  status;
        logic        last;
    } out_t;

    // mirror contents seen by the current event
    typedef struct packed {
        logic [15:0] tone_per;
        logic [7:0]  mixer;
        logic [15:0] wave_per;
        logic [7:0]  fm_vol;
        logic [7:0]  fm_hi;
        logic [15:0] fm_pitch;
        logic [15:0] count;
    } view_t;

    // mirror updates committed when the event retires
    typedef struct packed {
        logic        tp_lo_we;
        logic        tp_hi_we;
        logic [1:0]  tp_idx;
        logic [15:0] tp_val;
        logic        mixer_we;
        logic [7:0]  mixer_val;
        logic        wave_we;
        logic [15:0] wave_val;
        logic        fm_vol_we;
        logic [3:0]  fm_vol_idx;
        logic [7:0]  fm_vol_val;
        logic        fm_hi_we;
        logic [3:0]  fm_hi_idx;
        logic [7:0]  fm_hi_val;
        logic        fm_pitch_we;
        logic [15:0] fm_pitch_val;
        logic [15:0] count_val;
    } upd_t;

endpackage
`default_nettype wire

// ----- src/sound_event_register_mapper_core.sv -----
// Top level of the sound event register mapper: event register, mirror state
// and result register. Depends on smr_pkg and smr_map.
//
// Usage: one music event enters per s_valid/s_ready beat on s_data; every
// event yields one or two result beats on m_data, the final one with last set.
// Events that make no register write give a single status beat.
// The event is held in the event register; its first result is registered in
// the output register. The result register is shared by both beats of an event,
// so an event with two writes occupies it for its first beat, then its second.
// A new event is taken in the cycle its last beat moves into the output
// register, so events stream back to back when the receiver keeps up.
// Mirrors and the write count update when the event retires.
// Reset (aresetn low, synchronous) empties both registers and restores the
// mirror reset values: mixer 0xB8, FM volume/instrument bytes 0x0F, rest zero.
// When the receiver stalls, the result beat holds and the held event does not advance.
`default_nettype none
module sound_event_register_mapper_core #(
    parameter int TRACK_COUNT = smr_pkg::TRACK_COUNT_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire smr_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output smr_pkg::out_t      m_data
);

    localparam int FM_COUNT = TRACK_COUNT - 8;
    localparam int FM_IW    = (FM_COUNT > 1) ? $clog2(FM_COUNT) : 1;

    smr_pkg::in_t   ev_reg;
    logic           ev_valid_reg;
    logic           phase_reg;
    smr_pkg::out_t  out_reg;
    logic           m_valid_reg;

    logic [15:0] tone_per_reg [3];
    logic [7:0]  mixer_reg;
    logic [15:0] wave_per_reg [5];
    logic [7:0]  fm_vol_reg   [FM_COUNT];
    logic [7:0]  fm_hi_reg    [FM_COUNT];
    logic [15:0] fm_pitch_reg [FM_COUNT];
    logic [15:0] count_reg;

    smr_pkg::view_t view;
    smr_pkg::out_t  res0, res1;
    smr_pkg::upd_t  upd;
    logic           two, out_free, done;
    logic [1:0]     tch;
    logic [2:0]     wch;
    logic [3:0]     fch;
    logic           fch_ok;

    always_comb begin
        tch    = ev_reg.track[1:0];
        wch    = 3'(ev_reg.track - 5'd3);
        fch    = 4'(ev_reg.track - 5'd8);
        fch_ok = 32'(fch) < 32'(FM_COUNT);
        view.tone_per = (tch < 2'd3) ? tone_per_reg[tch] : 16'd0;
        view.mixer    = mixer_reg;
        view.wave_per = (wch < 3'd5) ? wave_per_reg[wch] : 16'd0;
        view.fm_vol   = fch_ok ? fm_vol_reg[fch[FM_IW-1:0]]   : 8'd0;
        view.fm_hi    = fch_ok ? fm_hi_reg[fch[FM_IW-1:0]]    : 8'd0;
        view.fm_pitch = fch_ok ? fm_pitch_reg[fch[FM_IW-1:0]] : 16'd0;
        view.count    = count_reg;
    end

    smr_map #(.TRACK_COUNT(TRACK_COUNT)) u_map (
        .ev   (ev_reg),
        .view (view),
        .res0 (res0),
        .res1 (res1),
        .two  (two),
        .upd  (upd)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign done     = ev_valid_reg && out_free && (!two || phase_reg);
    assign s_ready  = !ev_valid_reg || done;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                ev_valid_reg <= s_valid;
            end
            if (ev_valid_reg && out_free) begin
                m_valid_reg <= 1'b1;
                phase_reg   <= !done;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            ev_reg <= s_data;
        end
        if (ev_valid_reg && out_free) begin
            out_reg <= phase_reg ? res1 : res0;
        end
    end

    // commit the mirror updates as the event retires
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) tone_per_reg[i] <= 16'd0;
            for (int i = 0; i < 5; i++) wave_per_reg[i] <= 16'd0;
            for (int i = 0; i < FM_COUNT; i++) begin
                fm_vol_reg[i]   <= smr_pkg::FM_VOL_RESET;
                fm_hi_reg[i]    <= 8'd0;
                fm_pitch_reg[i] <= 16'd0;
            end
            mixer_reg <= smr_pkg::MIXER_RESET;
            count_reg <= 16'd0;
        end else if (done) begin
            count_reg <= upd.count_val;
            if (upd.tp_idx < 2'd3) begin
                if (upd.tp_lo_we) tone_per_reg[upd.tp_idx][7:0]  <= upd.tp_val[7:0];
                if (upd.tp_hi_we) tone_per_reg[upd.tp_idx][15:8] <= upd.tp_val[15:8];
            end
            if (upd.mixer_we) mixer_reg <= upd.mixer_val;
            if (upd.wave_we && wch < 3'd5) wave_per_reg[wch] <= upd.wave_val;
            if (upd.fm_vol_we && 32'(upd.fm_vol_idx) < 32'(FM_COUNT)) begin
                fm_vol_reg[upd.fm_vol_idx[FM_IW-1:0]] <= upd.fm_vol_val;
            end
            if (upd.fm_hi_we && 32'(upd.fm_hi_idx) < 32'(FM_COUNT)) begin
                fm_hi_reg[upd.fm_hi_idx[FM_IW-1:0]] <= upd.fm_hi_val;
            end
            if (upd.fm_pitch_we && fch_ok) begin
                fm_pitch_reg[fch[FM_IW-1:0]] <= upd.fm_pitch_val;
            end
        end
    end

    a_phase_has_event: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> ev_valid_reg)
        else $error("second beat pending without a held event");

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.status != smr_pkg::ST_OK) |->
            (!out_reg.write_valid && out_reg.last))
        else $error("status beat is not a lone final beat");

    a_second_beat_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (ev_valid_reg && out_free && phase_reg) |=> (m_valid_reg && out_reg.last))
        else $error("second write beat not marked last");

endmodule
`default_nettype wire

// ----- src/smr_map.sv -----
// Event decode: turns one held event and the mirror view into up to two
// result beats and the mirror updates. Depends on smr_pkg.
`default_nettype none
module smr_map #(
    parameter int TRACK_COUNT = smr_pkg::TRACK_COUNT_DEF
) (
    input  wire smr_pkg::in_t   ev,
    input  wire smr_pkg::view_t view,
    output smr_pkg::out_t       res0,
    output smr_pkg::out_t       res1,
    output logic                two,
    output smr_pkg::upd_t       upd
);

    logic signed [15:0] a, b, vsrc;
    logic [3:0]  vol;
    logic [15:0] cbase, p, pf;
    logic [1:0]  nw;
    logic [2:0]  status;
    logic [1:0]  chip, port0, port1;
    logic [7:0]  ad0, ad1, va0, va1;
    logic [2:0]  rs0, rs1;
    logic [1:0]  tch;
    logic [2:0]  wch;
    logic [3:0]  fch;
    logic        a_tone_ok, a_fm_ok, b_ok, a_patch_ok;
    logic [7:0]  mix, tm, nm;

    always_comb begin
        a     = ev.arg_a;
        b     = ev.arg_b;
        cbase = ev.tick_start ? 16'd0 : view.count;
        vsrc  = (ev.cmd == smr_pkg::CMD_RATE_VOL) ? b : a;
        vol   = vsrc[15] ? 4'd0 : ((vsrc[14:4] != 11'd0) ? 4'd15 : vsrc[3:0]);
        tch   = ev.track[1:0];
        wch   = 3'(ev.track - 5'd3);
        fch   = 4'(ev.track - 5'd8);
        a_tone_ok  = !a[15] && (a[14:4] == 11'd0);
        a_fm_ok    = !a[15] && (a[14:0] <= 15'd56);
        a_patch_ok = !a[15] && (a[14:0] <= 15'd14);
        b_ok       = !b[15] && (b[14:8] == 7'd0);
        tm = 8'd1 << tch;
        nm = 8'd1 << (3'(tch) + 3'd3);
        mix = view.mixer;
        mix = a[0] ? (mix & ~tm) : (mix | tm);
        mix = a[1] ? (mix & ~nm) : (mix | nm);
        p  = 16'd0;
        pf = 16'd0;

        nw = 2'd0; status = smr_pkg::ST_OK;
        chip = smr_pkg::CHIP_TONE; port0 = 2'd0; port1 = 2'd0;
        ad0 = 8'd0; ad1 = 8'd0; va0 = 8'd0; va1 = 8'd0;
        rs0 = smr_pkg::WR_VOLUME; rs1 = smr_pkg::WR_FREQ;
        upd = '0;
        upd.tp_idx = tch;

        if (32'(ev.track) >= 32'(TRACK_COUNT)) begin
            status = smr_pkg::ST_BAD_TRACK;
        end else if (ev.track < 5'd3) begin
            chip = smr_pkg::CHIP_TONE;
            unique case (ev.cmd) inside
                smr_pkg::CMD_VOLUME, smr_pkg::CMD_RATE_VOL: begin
                    nw = 2'd1; ad0 = 8'd8 + 8'(tch); va0 = 8'(vol);
                    rs0 = smr_pkg::WR_VOLUME;
                end
                smr_pkg::CMD_REG_WR: begin
                    if (!a_tone_ok || !b_ok) begin
                        status = smr_pkg::ST_BAD_REG;
                    end else begin
                        nw = 2'd1; ad0 = a[7:0]; va0 = b[7:0]; rs0 = smr_pkg::WR_ENV;
                        upd.tp_idx = a[2:1];
                        upd.tp_val = {b[7:0], b[7:0]};
                        if (a[3:0] < 4'd6) begin
                            upd.tp_lo_we = !a[0];
                            upd.tp_hi_we = a[0];
                        end
                        upd.mixer_we  = (a[3:0] == 4'd7);
                        upd.mixer_val = b[7:0];
                    end
                end
                smr_pkg::CMD_PERIOD: begin
                    p  = view.tone_per - 16'(a);
                    nw = 2'd2;
                    ad0 = {5'd0, tch, 1'b0}; va0 = p[7:0];  rs0 = smr_pkg::WR_FREQ;
                    ad1 = {5'd0, tch, 1'b1}; va1 = p[15:8];
                    upd.tp_lo_we = 1'b1; upd.tp_hi_we = 1'b1; upd.tp_val = p;
                end
                smr_pkg::CMD_NOISE: begin
                    nw = 2'd1; ad0 = 8'd6; va0 = {3'd0, a[4:0]}; rs0 = smr_pkg::WR_PATCH;
                end
                smr_pkg::CMD_MIXER: begin
                    nw = 2'd1; ad0 = 8'd7; va0 = mix; rs0 = smr_pkg::WR_PATCH;
                    upd.mixer_we = 1'b1; upd.mixer_val = mix;
                end
                smr_pkg::CMD_PATCH: status = smr_pkg::ST_OK;
                default: status = smr_pkg::ST_UNSUPPORTED;
            endcase
        end else if (ev.track < 5'd8) begin
            chip = smr_pkg::CHIP_WAVE;
            unique case (ev.cmd) inside
                smr_pkg::CMD_VOLUME, smr_pkg::CMD_RATE_VOL: begin
                    nw = 2'd1; port0 = 2'd2; ad0 = 8'(wch); va0 = 8'(vol);
                    rs0 = smr_pkg::WR_VOLUME;
                end
                smr_pkg::CMD_PATCH: status = smr_pkg::ST_NO_PATCH;
                smr_pkg::CMD_PERIOD: begin
                    p  = view.wave_per - 16'(a);
                    nw = 2'd2; port0 = 2'd1; port1 = 2'd1;
                    ad0 = {4'd0, wch, 1'b0}; va0 = p[7:0]; rs0 = smr_pkg::WR_FREQ;
                    ad1 = {4'd0, wch, 1'b1}; va1 = p[15:8];
                    upd.wave_we = 1'b1; upd.wave_val = p;
                end
                smr_pkg::CMD_UNSUP: status = smr_pkg::ST_UNSUPPORTED;
                default: status = smr_pkg::ST_OK;
            endcase
        end else begin
            chip = smr_pkg::CHIP_FM;
            unique case (ev.cmd) inside
                smr_pkg::CMD_VOLUME, smr_pkg::CMD_RATE_VOL: begin
                    nw = 2'd1; ad0 = smr_pkg::FM_VOL_BASE + 8'(fch);
                    va0 = (view.fm_vol & 8'hF0) | {4'd0, vol ^ 4'hF};
                    rs0 = smr_pkg::WR_VOLUME;
                    upd.fm_vol_we = 1'b1; upd.fm_vol_idx = fch; upd.fm_vol_val = va0;
                end
                smr_pkg::CMD_PATCH: begin
                    if (!a_patch_ok) begin
                        status = smr_pkg::ST_NO_PATCH;
                    end else begin
                        nw = 2'd1; ad0 = smr_pkg::FM_VOL_BASE + 8'(fch);
                        va0 = {a[3:0] + 4'd1, view.fm_vol[3:0]};
                        rs0 = smr_pkg::WR_PATCH;
                        upd.fm_vol_we = 1'b1; upd.fm_vol_idx = fch; upd.fm_vol_val = va0;
                    end
                end
                smr_pkg::CMD_REG_WR: begin
                    if (!a_fm_ok || !b_ok) begin
                        status = smr_pkg::ST_BAD_REG;
                    end else begin
                        nw = 2'd1; ad0 = a[7:0]; va0 = b[7:0];
                        rs0 = (a[7:0] == smr_pkg::FM_RHYTHM) ? smr_pkg::WR_RHYTHM
                                                              : smr_pkg::WR_ENV;
                        upd.fm_hi_we  = (a[7:0] >= smr_pkg::FM_HI_BASE) &&
                                        (a[7:0] <  smr_pkg::FM_HI_BASE + 8'd9);
                        upd.fm_hi_idx = 4'(a[7:0] - smr_pkg::FM_HI_BASE);
                        upd.fm_hi_val = b[7:0];
                        upd.fm_vol_we  = (a[7:0] >= smr_pkg::FM_VOL_BASE);
                        upd.fm_vol_idx = 4'(a[7:0] - smr_pkg::FM_VOL_BASE);
                        upd.fm_vol_val = b[7:0];
                    end
                end
                smr_pkg::CMD_PERIOD: begin
                    p = view.fm_pitch + 16'(a);
                    // snap the pitch back into the octave window
                    if (p[8]) begin
                        pf = (p[7:0] >= smr_pkg::FM_SNAP_HI) ? p + smr_pkg::FM_STEP_UP : p;
                    end else begin
                        pf = (p[7:0] < smr_pkg::FM_SNAP_LO) ? p + smr_pkg::FM_STEP_DN : p;
                    end
                    nw = 2'd2;
                    ad0 = smr_pkg::FM_HI_BASE + 8'(fch);
                    va0 = (view.fm_hi & 8'h30) | pf[15:8];
                    rs0 = smr_pkg::WR_FREQ;
                    ad1 = smr_pkg::FM_LO_BASE + 8'(fch); va1 = pf[7:0];
                    upd.fm_pitch_we = 1'b1; upd.fm_pitch_val = pf;
                    upd.fm_hi_we = 1'b1; upd.fm_hi_idx = fch; upd.fm_hi_val = va0;
                end
                smr_pkg::CMD_UNSUP: status = smr_pkg::ST_UNSUPPORTED;
                default: status = smr_pkg::ST_OK;
            endcase
        end

        upd.count_val = cbase + 16'(nw);
        two = (nw == 2'd2);

        res0 = '0;
        res0.stamp        = ev.tick_time;
        res0.source_track = ev.track;
        res0.last         = 1'b1;
        res1 = res0;
        if (nw == 2'd0) begin
            res0.status = status;
        end else begin
            res0.write_valid     = 1'b1;
            res0.chip            = chip;
            res0.bus_port        = port0;
            res0.reg_address     = ad0;
            res0.reg_value       = va0;
            res0.write_reason    = rs0;
            res0.sequence_number = cbase;
            res0.last            = (nw == 2'd1);
        end
        res1.write_valid     = 1'b1;
        res1.chip            = chip;
        res1.bus_port        = port1;
        res1.reg_address     = ad1;
        res1.reg_value       = va1;
        res1.write_reason    = rs1;
        res1.sequence_number = cbase + 16'd1;
    end

endmodule
`default_nettype wire
